// File: design/q_learning_table_update_defines.svh
// Assertion macros for the Q-learning table update block.
`ifndef Q_LEARNING_TABLE_UPDATE_DEFINES_SVH
`define Q_LEARNING_TABLE_UPDATE_DEFINES_SVH
`ifndef SYNTH
`define QLTU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qltu check failed");
`define QLTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qltu check failed");
`else
`define QLTU_ASSERT_NOW(label, ante, cons)
`define QLTU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/qltu_pkg.sv
// Shared types, register codes and helpers for the Q-learning table update block.
package qltu_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DISCOUNT = 2'd0;
    localparam logic [1:0] REG_RATE     = 2'd1;
    localparam logic [1:0] REG_EXPLORE  = 2'd2;

    localparam logic [15:0] DISCOUNT_RESET = 16'd58982;
    localparam logic [15:0] RATE_RESET     = 16'd6554;
    localparam logic [15:0] EXPLORE_RESET  = 16'd6554;

    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = -24'sh800000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic pow_step;
        logic scan_step;
        logic rd_cur;
        logic cap_cur;
        logic calc_disc;
        logic calc_step;
        logic wr_new;
    } qltu_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic pow_done;
        logic scan_last;
        logic learn;
    } qltu_sts_t;

    // Remainder of an 8-bit index by a modulus, restoring style, 8 steps
    function automatic logic [7:0] qltu_mod8(input logic [7:0] x, input int unsigned m);
        logic [31:0] r;
        r = {24'b0, x};
        for (int k = 7; k >= 0; k--) begin
            if (r >= (32'(m) << k)) begin
                r = r - (32'(m) << k);
            end
        end
        return r[7:0];
    endfunction

endpackage

// File: design/qltu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qltu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/qltu_ctrl.sv
// Sequencer for the Q-learning table update: clear pass, scans, update, handshakes.
module qltu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  qltu_pkg::qltu_sts_t sts,
    output qltu_pkg::qltu_cmd_t cmd
);
    import qltu_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_POW    = 4'd2;
    localparam logic [3:0] S_SCAN1  = 4'd3;
    localparam logic [3:0] S_RDCUR  = 4'd4;
    localparam logic [3:0] S_CAPCUR = 4'd5;
    localparam logic [3:0] S_DISC   = 4'd6;
    localparam logic [3:0] S_STEP   = 4'd7;
    localparam logic [3:0] S_WRITE  = 4'd8;
    localparam logic [3:0] S_SCAN2  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (!sts.learn)
                begin
                    state_next = S_RDCUR;
                end
                else if (sts.pow_done)
                begin
                    state_next = S_SCAN1;
                end
                else
                begin
                    cmd.pow_step = 1'b1;
                end
            end
            S_SCAN1:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_RDCUR;
                end
            end
            S_RDCUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_CAPCUR;
            end
            S_CAPCUR:
            begin
                cmd.cap_cur = 1'b1;
                state_next  = sts.learn ? S_DISC : S_SCAN2;
            end
            S_DISC:
            begin
                cmd.calc_disc = 1'b1;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                cmd.calc_step = 1'b1;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_SCAN2;
            end
            S_SCAN2:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/qltu_dp.sv
// Datapath: value table, row scan for the best action, discount power and update math.
module qltu_dp #(
    parameter int STATE_COUNT  = 256,
    parameter int ACTION_COUNT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qltu_pkg::qltu_cmd_t cmd,
    output qltu_pkg::qltu_sts_t sts,
    input  logic [7:0]          current_state,
    input  logic [2:0]          taken_action,
    input  logic signed [23:0]  reward_value,
    input  logic [7:0]          next_state,
    input  logic [7:0]          step_count,
    input  logic [15:0]         random_sample,
    input  logic [2:0]          random_pick,
    input  logic                learn,
    input  logic [15:0]         discount_factor,
    input  logic [15:0]         learning_rate,
    input  logic [15:0]         explore_threshold,
    output logic [2:0]          chosen_action,
    output logic                explored,
    output logic signed [23:0]  updated_value
);
    import qltu_pkg::*;

    localparam int DEPTH = STATE_COUNT * ACTION_COUNT;
    localparam int ADW   = $clog2(DEPTH);
    localparam int AIW   = $clog2(ACTION_COUNT);

    // Item registers
    logic [ADW-1:0]        cur_addr_reg;
    logic [ADW-1:0]        ns_base_reg;
    logic signed [23:0]    reward_reg;
    logic [7:0]            dur_reg;
    logic [2:0]            pick_reg;
    logic                  explored_reg;
    logic                  learn_reg;

    // Arithmetic registers
    logic [16:0]           p_reg;
    logic signed [23:0]    cur_reg;
    logic signed [25:0]    disc_reg;
    logic signed [27:0]    step_reg;
    logic signed [23:0]    upd_reg;

    // Scan and clear counters
    logic [AIW-1:0]        scan_cnt_reg;
    logic [AIW-1:0]        lag_idx_reg;
    logic                  scan_vld_reg;
    logic signed [23:0]    best_val_reg;
    logic [AIW-1:0]        best_idx_reg;
    logic [ADW-1:0]        clr_cnt_reg;

    // RAM ports
    logic                  ram_we;
    logic [ADW-1:0]        ram_waddr;
    logic [23:0]           ram_wdata;
    logic                  ram_re;
    logic [ADW-1:0]        ram_raddr;
    logic [23:0]           ram_rdata;

    // Index reduction and addressing
    logic [7:0]            s_red;
    logic [7:0]            ns_red;
    logic [7:0]            a_red;
    logic [7:0]            pick_red;

    assign s_red    = qltu_mod8(current_state, STATE_COUNT);
    assign ns_red   = qltu_mod8(next_state, STATE_COUNT);
    assign a_red    = qltu_mod8({5'b0, taken_action}, ACTION_COUNT);
    assign pick_red = qltu_mod8({5'b0, random_pick}, ACTION_COUNT);

    // Arithmetic
    logic [32:0]           pow_prod;
    logic [33:0]           pow_sum;
    logic signed [41:0]    disc_prod;
    logic signed [41:0]    disc_sum;
    logic signed [26:0]    err;
    logic signed [43:0]    step_prod;
    logic signed [43:0]    step_sum;
    logic signed [28:0]    nv_wide;
    logic signed [23:0]    nv_sat;

    assign pow_prod  = p_reg * discount_factor;
    assign pow_sum   = 34'(pow_prod) + 34'd32768;
    assign disc_prod = $signed({1'b0, p_reg}) * best_val_reg;
    assign disc_sum  = disc_prod + 42'sd32768;
    assign err       = 27'(reward_reg) + 27'(disc_reg) - 27'(cur_reg);
    assign step_prod = $signed({1'b0, learning_rate}) * err;
    assign step_sum  = step_prod + 44'sd32768;
    assign nv_wide   = 29'(cur_reg) + 29'(step_reg);

    // Saturate to the Q11.12 range
    always_comb
    begin
        if (nv_wide > 29'(Q_MAX))
        begin
            nv_sat = Q_MAX;
        end
        else if (nv_wide < 29'(Q_MIN))
        begin
            nv_sat = Q_MIN;
        end
        else
        begin
            nv_sat = 24'(nv_wide);
        end
    end

    // RAM port muxing: clear pass or update on write, scan or current on read
    assign ram_we    = cmd.clr_step | cmd.wr_new;
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : cur_addr_reg;
    assign ram_wdata = cmd.clr_step ? 24'd0 : nv_sat;
    assign ram_re    = cmd.scan_step | cmd.rd_cur;
    assign ram_raddr = cmd.scan_step ? (ns_base_reg + ADW'(scan_cnt_reg)) : cur_addr_reg;

    qltu_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            scan_vld_reg <= 1'b0;
            lag_idx_reg  <= '0;
            learn_reg    <= 1'b0;
            dur_reg      <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                scan_cnt_reg <= sts.scan_last ? '0 : scan_cnt_reg + 1'b1;
            end
            scan_vld_reg <= cmd.scan_step;
            lag_idx_reg  <= scan_cnt_reg;
            if (cmd.load)
            begin
                learn_reg <= learn;
                dur_reg   <= step_count;
            end
            else if (cmd.pow_step)
            begin
                dur_reg <= dur_reg - 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_addr_reg <= ADW'(s_red) * ADW'(ACTION_COUNT) + ADW'(a_red);
            ns_base_reg  <= ADW'(ns_red) * ADW'(ACTION_COUNT);
            reward_reg   <= reward_value;
            pick_reg     <= 3'(pick_red);
            explored_reg <= (random_sample < explore_threshold);
            p_reg        <= 17'h10000;
        end
        else if (cmd.pow_step)
        begin
            p_reg <= 17'(pow_sum >> 16);
        end
        // Best of the row, lowest index wins ties
        if (scan_vld_reg && ((lag_idx_reg == '0) || ($signed(ram_rdata) > best_val_reg)))
        begin
            best_val_reg <= $signed(ram_rdata);
            best_idx_reg <= lag_idx_reg;
        end
        if (cmd.cap_cur)
        begin
            cur_reg <= $signed(ram_rdata);
            upd_reg <= $signed(ram_rdata);
        end
        if (cmd.calc_disc)
        begin
            disc_reg <= 26'(disc_sum >>> 16);
        end
        if (cmd.calc_step)
        begin
            step_reg <= 28'(step_sum >>> 16);
        end
        if (cmd.wr_new)
        begin
            upd_reg <= nv_sat;
        end
    end

    assign sts.clr_last  = (clr_cnt_reg == ADW'(DEPTH - 1));
    assign sts.pow_done  = (dur_reg == 8'd0);
    assign sts.scan_last = (scan_cnt_reg == AIW'(ACTION_COUNT - 1));
    assign sts.learn     = learn_reg;

    assign chosen_action = explored_reg ? pick_reg : 3'(best_idx_reg);
    assign explored      = explored_reg;
    assign updated_value = upd_reg;

endmodule

// File: design/q_learning_table_update.sv
// Top level of the Q-learning table update block.
// Tabular Q-learning with semi-Markov discounting over a STATE_COUNT x ACTION_COUNT table of
// signed Q11.12 values. One item is in work at a time. After reset a clearing pass zeroes the
// table, one entry a cycle, and no beat is taken meanwhile. With learn set, an item runs the
// discount power with one step per unit of step_count and a check that it is done, one table
// read per action for the best next value, a read-modify-write of Q(s,a) in the read, capture,
// discount, step and write states, a second row scan for the greedy choice, and a settle state
// for the choice. With learn clear the power, the first scan and the update math are skipped:
// the current entry is read and captured, then the second row scan and the settle state follow.
// The result beat holds until taken, and the next input beat can be taken the cycle after.
// The single read port of the table RAM sets this sequence.
`include "q_learning_table_update_defines.svh"
module q_learning_table_update #(
    parameter int STATE_COUNT  = 256,
    parameter int ACTION_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         current_state,
    input  logic [2:0]         taken_action,
    input  logic signed [23:0] reward_value,
    input  logic [7:0]         next_state,
    input  logic [7:0]         step_count,
    input  logic [15:0]        random_sample,
    input  logic [2:0]         random_pick,
    input  logic               learn,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         chosen_action,
    output logic               explored,
    output logic signed [23:0] updated_value,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import qltu_pkg::*;

    logic [15:0] discount_reg;
    logic [15:0] rate_reg;
    logic [15:0] explore_reg;
    logic        cfg_wr;
    qltu_cmd_t   cmd;
    qltu_sts_t   sts;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg <= DISCOUNT_RESET;
            rate_reg     <= RATE_RESET;
            explore_reg  <= EXPLORE_RESET;
        end
        else if (cfg_wr && (paddr[1:0] == 2'b00))
        begin
            unique case (paddr[3:2])
                REG_DISCOUNT: discount_reg <= pwdata[15:0];
                REG_RATE:     rate_reg     <= pwdata[15:0];
                REG_EXPLORE:  explore_reg  <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DISCOUNT: prdata = {16'd0, discount_reg};
            REG_RATE:     prdata = {16'd0, rate_reg};
            REG_EXPLORE:  prdata = {16'd0, explore_reg};
            default:      prdata = 32'd0;
        endcase
    end

    qltu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    qltu_dp #(
        .STATE_COUNT  (STATE_COUNT),
        .ACTION_COUNT (ACTION_COUNT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .current_state     (current_state),
        .taken_action      (taken_action),
        .reward_value      (reward_value),
        .next_state        (next_state),
        .step_count        (step_count),
        .random_sample     (random_sample),
        .random_pick       (random_pick),
        .learn             (learn),
        .discount_factor   (discount_reg),
        .learning_rate     (rate_reg),
        .explore_threshold (explore_reg),
        .chosen_action     (chosen_action),
        .explored          (explored),
        .updated_value     (updated_value)
    );

    // Checks
    `QLTU_ASSERT_NOW(a_one_item, in_valid && !in_stall, !out_valid)
    `QLTU_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall)
    `QLTU_ASSERT_NEXT(a_discount_wr, cfg_wr && (paddr == 4'd0), discount_reg == $past(pwdata[15:0]))

endmodule
